// ===== sv/fcu_pkg.sv =====
// shared types, constants and helpers for the free-fly camera update block
// no dependencies; used by fcu_mul and fly_camera_update
package fcu_pkg;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ANG  = 8'b0000_0010,
		ST_CORD = 8'b0000_0100,
		ST_PROD = 8'b0000_1000,
		ST_SQRT = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_MOVE = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	localparam logic [2:0] CFG_MOVE_SPEED = 3'd0;
	localparam logic [2:0] CFG_LOOK_GAIN  = 3'd1;
	localparam logic [2:0] CFG_UP_X       = 3'd2;
	localparam logic [2:0] CFG_UP_Y       = 3'd3;
	localparam logic [2:0] CFG_UP_Z       = 3'd4;

	// angles in Q9.16 degrees
	localparam logic [32:0] YAW_FULL  = 33'd23592960;
	localparam logic [34:0] YAW_BIAS  = 35'd3019898880; // 128 turns
	localparam logic signed [34:0] PITCH_LIM = 35'sd5832704;
	localparam logic [26:0] DEG90     = 27'd5898240;
	localparam logic [26:0] DEG180    = 27'd11796480;
	localparam logic [26:0] DEG270    = 27'd17694720;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	// arctangent of 2^-i in degrees Q.24
	localparam logic [29:0] ATAN_DEG [24] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115
	};

	function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
		logic signed [15:0] r;
		if (v > PROD_W'(32767)) begin
			r = 16'sd32767;
		end else if (v < -PROD_W'(32768)) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/fcu_mul.sv =====
// shared signed multiplier with registered product
// depends on fcu_pkg for operand and product widths
module fcu_mul (
	input  logic                              clk,
	input  logic signed [fcu_pkg::MUL_W-1:0]  a,
	input  logic signed [fcu_pkg::MUL_W-1:0]  b,
	output logic signed [fcu_pkg::PROD_W-1:0] p
);
	import fcu_pkg::*;

	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ===== sv/fly_camera_update.sv =====
// free-fly camera update: top level with sequencer and iterative datapath
// depends on fcu_pkg and fcu_mul
//
// One frame per transfer. The block takes a frame only when idle and then works on it in
// order: the angle update and yaw wrap, one CORDIC step per cycle for pitch and then yaw,
// the products on the shared multiplier, the square root, the divider for each right
// component (skipped when the right vector is degenerate) and the moves. Every product
// goes through one registered 33x33 multiplier. A finished result sits in the output
// register, so the next frame can be taken while it waits for out_ready.
module fly_camera_update #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] mouse_dx,
	input  logic signed [15:0] mouse_dy,
	input  logic [15:0]        frame_time,
	input  logic               key_forward,
	input  logic               key_back,
	input  logic               key_left,
	input  logic               key_right,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);
	import fcu_pkg::*;

	localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);

	state_t state_q;
	logic [4:0] cnt_q;

	logic [15:0] move_speed_q, look_gain_q;
	logic signed [15:0] up_x_q, up_y_q, up_z_q;

	logic signed [15:0] dx_q, dy_q;
	logic [15:0] dt_q;
	logic [3:0] keys_q;

	logic [31:0] yaw_q;
	logic signed [31:0] pitch_q;
	logic [32:0] red_q;

	logic signed [33:0] cx_q, cy_q, z_q;
	logic pass_q, flip_q;
	logic signed [31:0] cp_q, cyw_q, syw_q;
	logic signed [15:0] fx_q, fy_q, fz_q;
	logic signed [32:0] crx_q, cry_q, crz_q;
	logic [63:0] len2_q, sv_q, sr_q;
	logic [31:0] scale_q, len_q;
	logic [47:0] num_q;
	logic [14:0] quo_q;
	logic [1:0] cmp_q;
	logic signed [15:0] rdir_q [3];
	logic signed [34:0] step_q [6];
	logic signed [31:0] pos_q [3];

	logic out_valid_q;
	logic signed [15:0] odir_q [3];
	logic signed [31:0] opos_q [3];

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	fcu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// multiplier operand schedule
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ANG: begin
				mul_a = (cnt_q == 5'd0) ? MUL_W'(dx_q) : MUL_W'(dy_q);
				mul_b = MUL_W'(look_gain_q);
			end
			ST_PROD: begin
				priority case (cnt_q)
					5'd0:  begin mul_a = MUL_W'(cyw_q); mul_b = MUL_W'(cp_q); end
					5'd1:  begin mul_a = MUL_W'(syw_q); mul_b = MUL_W'(cp_q); end
					5'd2:  begin mul_a = MUL_W'(fy_q);  mul_b = MUL_W'(up_z_q); end
					5'd3:  begin mul_a = MUL_W'(fz_q);  mul_b = MUL_W'(up_y_q); end
					5'd4:  begin mul_a = MUL_W'(fz_q);  mul_b = MUL_W'(up_x_q); end
					5'd5:  begin mul_a = MUL_W'(fx_q);  mul_b = MUL_W'(up_z_q); end
					5'd6:  begin mul_a = MUL_W'(fx_q);  mul_b = MUL_W'(up_y_q); end
					5'd7:  begin mul_a = MUL_W'(fy_q);  mul_b = MUL_W'(up_x_q); end
					5'd9:  begin mul_a = crx_q; mul_b = crx_q; end
					5'd10: begin mul_a = cry_q; mul_b = cry_q; end
					5'd11: begin mul_a = crz_q; mul_b = crz_q; end
					5'd12: begin mul_a = MUL_W'(move_speed_q); mul_b = MUL_W'(dt_q); end
					default: ;
				endcase
			end
			ST_MOVE: begin
				mul_b = MUL_W'(scale_q);
				priority case (cnt_q)
					5'd0: mul_a = MUL_W'(fx_q);
					5'd1: mul_a = MUL_W'(fy_q);
					5'd2: mul_a = MUL_W'(fz_q);
					5'd3: mul_a = MUL_W'(rdir_q[0]);
					5'd4: mul_a = MUL_W'(rdir_q[1]);
					5'd5: mul_a = MUL_W'(rdir_q[2]);
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// angle update
	logic signed [34:0] v_sum, v_fix, pit_new;
	logic [2:0] red_k;
	logic [32:0] red_sub;
	logic signed [26:0] yaw_ext, yaw_fold;
	logic yaw_flip;

	always_comb begin
		v_sum = 35'($signed({1'b0, yaw_q})) + 35'($signed(mul_p[33:0]));
		v_fix = v_sum[34] ? v_sum + $signed(YAW_BIAS) : v_sum;
		pit_new = 35'(pitch_q) - 35'($signed(mul_p[33:0]));
		red_k = 3'(5'd9 - cnt_q);
		red_sub = YAW_FULL << red_k;
		yaw_ext = $signed({2'b0, yaw_q[24:0]});
		yaw_flip = 1'b0;
		if (yaw_ext > $signed(DEG90) && yaw_ext < $signed(DEG270)) begin
			yaw_fold = yaw_ext - $signed(DEG180);
			yaw_flip = 1'b1;
		end else if (yaw_ext >= $signed(DEG270)) begin
			yaw_fold = yaw_ext - $signed(YAW_FULL[26:0]);
		end else begin
			yaw_fold = yaw_ext;
		end
	end

	// one cordic rotation per cycle
	logic signed [33:0] xs, ys, atn, x_n, y_n, z_n;
	logic signed [PROD_W-1:0] fy_rnd;

	always_comb begin
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		atn = $signed({4'b0, ATAN_DEG[cnt_q]});
		if (!z_q[33]) begin
			x_n = cx_q - ys;
			y_n = cy_q + xs;
			z_n = z_q - atn;
		end else begin
			x_n = cx_q + ys;
			y_n = cy_q - xs;
			z_n = z_q + atn;
		end
		fy_rnd = (PROD_W'(y_n) + (PROD_W'(1) <<< 15)) >>> 16;
	end

	logic signed [PROD_W-1:0] rnd46, rnd14;
	assign rnd46 = (mul_p + (PROD_W'(1) <<< 45)) >>> 46;
	assign rnd14 = (mul_p + (PROD_W'(1) <<< 13)) >>> 14;

	// square root, one result bit per cycle
	logic [63:0] sq_bit, sq_t, sr_n;
	logic sq_ge;

	always_comb begin
		sq_bit = 64'd1 << (6'd62 - {cnt_q, 1'b0});
		sq_t = sr_q + sq_bit;
		sq_ge = sv_q >= sq_t;
		sr_n = sq_ge ? (sr_q >> 1) + sq_bit : sr_q >> 1;
	end

	// restoring divider, one quotient bit per cycle
	logic [3:0] dv_k;
	logic [47:0] dv_sh, num_n;
	logic [14:0] quo_n;
	logic signed [32:0] dv_c;
	logic [32:0] dv_neg;
	logic [31:0] dv_mag;
	logic dv_ge;

	always_comb begin
		dv_k = 4'(5'd15 - cnt_q);
		dv_sh = 48'(len_q) << dv_k;
		dv_ge = num_q >= dv_sh;
		num_n = dv_ge ? num_q - dv_sh : num_q;
		quo_n = dv_ge ? quo_q | (15'd1 << dv_k) : quo_q;
		priority case (cmp_q)
			2'd0: dv_c = crx_q;
			2'd1: dv_c = cry_q;
			default: dv_c = crz_q;
		endcase
		dv_neg = -dv_c;
		dv_mag = dv_c[32] ? dv_neg[31:0] : dv_c[31:0];
	end

	// key moves, one key per cycle on all three axes
	logic signed [31:0] ap_pos [3];
	logic signed [34:0] ap_sel;
	logic ap_neg, ap_en;

	always_comb begin
		ap_neg = (cnt_q == 5'd8) || (cnt_q == 5'd9);
		ap_en = (cnt_q == 5'd7 && keys_q[0]) || (cnt_q == 5'd8 && keys_q[1])
			|| (cnt_q == 5'd9 && keys_q[2]) || (cnt_q == 5'd10 && keys_q[3]);
		for (int j = 0; j < 3; j++) begin
			ap_sel = (cnt_q == 5'd7 || cnt_q == 5'd8) ? step_q[j] : step_q[j + 3];
			ap_pos[j] = sat32(36'(pos_q[j]) + (ap_neg ? -36'(ap_sel) : 36'(ap_sel)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			move_speed_q <= 16'd50;
			look_gain_q <= 16'd2048;
			up_x_q <= '0;
			up_y_q <= 16'sd16384;
			up_z_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			dt_q <= '0;
			keys_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
			red_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			z_q <= '0;
			pass_q <= 1'b0;
			flip_q <= 1'b0;
			cp_q <= '0;
			cyw_q <= '0;
			syw_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
			fz_q <= '0;
			crx_q <= '0;
			cry_q <= '0;
			crz_q <= '0;
			len2_q <= '0;
			sv_q <= '0;
			sr_q <= '0;
			scale_q <= '0;
			len_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			cmp_q <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				rdir_q[j] <= '0;
				pos_q[j] <= '0;
				odir_q[j] <= '0;
				opos_q[j] <= '0;
			end
			for (int j = 0; j < 6; j++) begin
				step_q[j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MOVE_SPEED: move_speed_q <= cfg_data;
					CFG_LOOK_GAIN:  look_gain_q <= cfg_data;
					CFG_UP_X:       up_x_q <= cfg_data;
					CFG_UP_Y:       up_y_q <= cfg_data;
					CFG_UP_Z:       up_z_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dx_q <= mouse_dx;
						dy_q <= mouse_dy;
						dt_q <= frame_time;
						keys_q <= {key_right, key_left, key_back, key_forward};
						cnt_q <= '0;
						state_q <= ST_ANG;
					end
				end
				ST_ANG: begin
					if (cnt_q == 5'd1) begin
						red_q <= v_fix[32:0];
					end
					if (cnt_q == 5'd2) begin
						if (pit_new > PITCH_LIM) begin
							pitch_q <= 32'(PITCH_LIM);
						end else if (pit_new < -PITCH_LIM) begin
							pitch_q <= 32'(-PITCH_LIM);
						end else begin
							pitch_q <= pit_new[31:0];
						end
					end
					// wrap yaw by conditional subtraction of shifted full turns
					if (cnt_q >= 5'd2 && cnt_q <= 5'd9 && red_q >= red_sub) begin
						red_q <= red_q - red_sub;
					end
					if (cnt_q == 5'd10) begin
						yaw_q <= red_q[31:0];
						cx_q <= CORDIC_X0;
						cy_q <= '0;
						z_q <= 34'(pitch_q) <<< 8;
						pass_q <= 1'b0;
						cnt_q <= '0;
						state_q <= ST_CORD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_CORD: begin
					if (cnt_q == CORD_LAST) begin
						cnt_q <= '0;
						if (!pass_q) begin
							cp_q <= x_n[31:0];
							fy_q <= sat16(fy_rnd);
							cx_q <= CORDIC_X0;
							cy_q <= '0;
							z_q <= 34'(yaw_fold) <<< 8;
							flip_q <= yaw_flip;
							pass_q <= 1'b1;
						end else begin
							cyw_q <= flip_q ? -x_n[31:0] : x_n[31:0];
							syw_q <= flip_q ? -y_n[31:0] : y_n[31:0];
							state_q <= ST_PROD;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
						cx_q <= x_n;
						cy_q <= y_n;
						z_q <= z_n;
					end
				end
				ST_PROD: begin
					cnt_q <= (cnt_q == 5'd13) ? 5'd0 : cnt_q + 5'd1;
					priority case (cnt_q)
						5'd1:  fx_q <= sat16(rnd46);
						5'd2:  fz_q <= sat16(rnd46);
						5'd3:  crx_q <= mul_p[32:0];
						5'd4:  crx_q <= crx_q - mul_p[32:0];
						5'd5:  cry_q <= mul_p[32:0];
						5'd6:  cry_q <= cry_q - mul_p[32:0];
						5'd7:  crz_q <= mul_p[32:0];
						5'd8:  crz_q <= crz_q - mul_p[32:0];
						5'd10: len2_q <= mul_p[63:0];
						5'd11: len2_q <= len2_q + mul_p[63:0];
						5'd12: len2_q <= len2_q + mul_p[63:0];
						5'd13: begin
							scale_q <= mul_p[31:0];
							sv_q <= len2_q;
							sr_q <= '0;
							state_q <= ST_SQRT;
						end
						default: ;
					endcase
				end
				ST_SQRT: begin
					// the count wraps to zero after the last bit
					cnt_q <= cnt_q + 5'd1;
					if (sq_ge) begin
						sv_q <= sv_q - sq_t;
					end
					sr_q <= sr_n;
					if (cnt_q == 5'd31) begin
						len_q <= sr_n[31:0];
						cmp_q <= '0;
						if (sr_n[31:0] == 32'd0) begin
							// degenerate cross product: right is zero
							for (int j = 0; j < 3; j++) begin
								rdir_q[j] <= '0;
							end
							state_q <= ST_MOVE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= (cnt_q == 5'd15) ? 5'd0 : cnt_q + 5'd1;
					if (cnt_q == 5'd0) begin
						num_q <= {2'b0, dv_mag, 14'b0} + 48'(len_q >> 1);
						quo_q <= '0;
					end else begin
						num_q <= num_n;
						quo_q <= quo_n;
					end
					if (cnt_q == 5'd15) begin
						rdir_q[cmp_q] <= dv_c[32] ? -16'(quo_n) : 16'(quo_n);
						if (cmp_q == 2'd2) begin
							state_q <= ST_MOVE;
						end else begin
							cmp_q <= cmp_q + 2'd1;
						end
					end
				end
				ST_MOVE: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q >= 5'd1 && cnt_q <= 5'd6) begin
						step_q[3'(cnt_q - 5'd1)] <= rnd14[34:0];
					end
					if (ap_en) begin
						for (int j = 0; j < 3; j++) begin
							pos_q[j] <= ap_pos[j];
						end
					end
					if (cnt_q == 5'd10) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						odir_q[0] <= fx_q;
						odir_q[1] <= fy_q;
						odir_q[2] <= fz_q;
						for (int j = 0; j < 3; j++) begin
							opos_q[j] <= pos_q[j];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign dir_x = odir_q[0];
	assign dir_y = odir_q[1];
	assign dir_z = odir_q[2];
	assign pos_x = opos_q[0];
	assign pos_y = opos_q[1];
	assign pos_z = opos_q[2];

	// a frame transfer always leaves the block busy for the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a frame is in flight");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(35'(pitch_q) <= PITCH_LIM) && (35'(pitch_q) >= -PITCH_LIM))
		else $error("pitch outside limit");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		33'(yaw_q) < YAW_FULL)
		else $error("yaw not wrapped");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for fly_camera_update: directed and random frames, random idling
// depends on fcu_pkg (config indexes, arctangent table) and the fly_camera_update rtl
module testbench;
	import fcu_pkg::*;

	localparam int STEPS = 16;
	localparam int LIMIT = 2_000_000;
	localparam int SETTLE = 200;

	typedef struct {
		logic signed [15:0] dx, dy;
		logic [15:0] ft;
		logic kf, kb, kl, kr;
	} frame_t;

	typedef struct {
		logic signed [15:0] dx, dy, dz;
		logic signed [31:0] px, py, pz;
	} pose_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] mouse_dx = '0, mouse_dy = '0;
	logic [15:0] frame_time = '0;
	logic key_forward = 0, key_back = 0, key_left = 0, key_right = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic signed [31:0] pos_x, pos_y, pos_z;

	frame_t frames_pending[$];
	pose_t poses_due[$];
	int mismatches = 0;
	int cycles = 0;
	int recv_hold = 0;
	bit calm = 0;

	// camera state and registers as the block should hold them
	logic [15:0] speed_r, gain_r;
	logic signed [15:0] upx_r, upy_r, upz_r;
	logic signed [31:0] yaw_r, pitch_r, posx_r, posy_r, posz_r;

	fly_camera_update #(.CORDIC_STEPS(STEPS)) dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rotate(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		x = CORDIC_X0;
		y = 0;
		z = ang * 256;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_DEG[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_DEG[i]);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint div_half_away(longint n, longint d);
		longint q;
		q = ((n < 0 ? -n : n) + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic logic signed [31:0] add_sat(logic signed [31:0] p, longint d);
		return 32'(clip(longint'(p) + d, -64'sd2147483648, 64'sd2147483647));
	endfunction

	function automatic pose_t camera_step(frame_t f);
		longint v, a, cp, sp, cy, sy, fx, fy, fz, ux, uy, uz, cx, cyr, cz;
		longint rx, ry, rz, scale;
		longint vec[3];
		longint unsigned len;
		bit flip;
		pose_t p;
		rx = 0; ry = 0; rz = 0;
		flip = 0;
		v = (longint'(yaw_r) + longint'(f.dx) * longint'(gain_r)) % 23592960;
		if (v < 0) v += 23592960;
		yaw_r = 32'(v);
		pitch_r = 32'(clip(longint'(pitch_r) - longint'(f.dy) * longint'(gain_r),
			-5832704, 5832704));
		rotate(pitch_r, cp, sp);
		a = yaw_r;
		if (a > DEG90 && a < DEG270) begin
			a -= DEG180;
			flip = 1;
		end else if (a >= DEG270) begin
			a -= 23592960;
		end
		rotate(a, cy, sy);
		if (flip) begin
			cy = -cy;
			sy = -sy;
		end
		fx = clip(round_shift(cy * cp, 46), -32768, 32767);
		fy = clip(round_shift(sp, 16), -32768, 32767);
		fz = clip(round_shift(sy * cp, 46), -32768, 32767);
		ux = upx_r; uy = upy_r; uz = upz_r;
		cx = fy * uz - fz * uy;
		cyr = fz * ux - fx * uz;
		cz = fx * uy - fy * ux;
		len = floor_sqrt(longint'(unsigned'(cx * cx)) + unsigned'(cyr * cyr)
			+ unsigned'(cz * cz));
		if (len != 0) begin
			rx = div_half_away(cx * 16384, longint'(len));
			ry = div_half_away(cyr * 16384, longint'(len));
			rz = div_half_away(cz * 16384, longint'(len));
		end
		scale = longint'(speed_r) * longint'(f.ft);
		// keys apply in order forward, back, left, right, each step saturating
		for (int k = 0; k < 4; k++) begin
			bit held;
			held = k == 0 ? f.kf : k == 1 ? f.kb : k == 2 ? f.kl : f.kr;
			if (held) begin
				if (k < 2) begin
					vec[0] = round_shift(fx * scale, 14);
					vec[1] = round_shift(fy * scale, 14);
					vec[2] = round_shift(fz * scale, 14);
				end else begin
					vec[0] = round_shift(rx * scale, 14);
					vec[1] = round_shift(ry * scale, 14);
					vec[2] = round_shift(rz * scale, 14);
				end
				if (k == 1 || k == 2) begin
					vec[0] = -vec[0]; vec[1] = -vec[1]; vec[2] = -vec[2];
				end
				posx_r = add_sat(posx_r, vec[0]);
				posy_r = add_sat(posy_r, vec[1]);
				posz_r = add_sat(posz_r, vec[2]);
			end
		end
		p.dx = 16'(fx); p.dy = 16'(fy); p.dz = 16'(fz);
		p.px = posx_r; p.py = posy_r; p.pz = posz_r;
		return p;
	endfunction

	// driver: each accepted frame is predicted at its transfer
	always @(posedge clk) begin
		frame_t f;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				f.dx = mouse_dx; f.dy = mouse_dy; f.ft = frame_time;
				f.kf = key_forward; f.kb = key_back; f.kl = key_left; f.kr = key_right;
				poses_due.push_back(camera_step(f));
			end
			if (!in_valid || in_ready) begin
				if (frames_pending.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
					f = frames_pending.pop_front();
					in_valid <= 1;
					mouse_dx <= f.dx; mouse_dy <= f.dy; frame_time <= f.ft;
					key_forward <= f.kf; key_back <= f.kb;
					key_left <= f.kl; key_right <= f.kr;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest expected pose
	always @(posedge clk) begin
		pose_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (poses_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer");
				end else begin
					e = poses_due.pop_front();
					if (dir_x !== e.dx || dir_y !== e.dy || dir_z !== e.dz ||
							pos_x !== e.px || pos_y !== e.py || pos_z !== e.pz) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp dir %0d %0d %0d pos %0d %0d %0d, got dir %0d %0d %0d pos %0d %0d %0d",
								e.dx, e.dy, e.dz, e.px, e.py, e.pz,
								dir_x, dir_y, dir_z, pos_x, pos_y, pos_z);
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_ready <= 0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= 29;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MOVE_SPEED: speed_r = val;
			CFG_LOOK_GAIN:  gain_r = val;
			CFG_UP_X:       upx_r = val;
			CFG_UP_Y:       upy_r = val;
			CFG_UP_Z:       upz_r = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_frame(int dx, int dy, int ft, bit [3:0] keys);
		frame_t f;
		f.dx = 16'(dx); f.dy = 16'(dy); f.ft = 16'(ft);
		{f.kf, f.kb, f.kl, f.kr} = keys;
		frames_pending.push_back(f);
	endtask

	task automatic add_random(int n);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				add_frame($urandom, $urandom, $urandom, $urandom);
			else
				add_frame($signed($urandom_range(512)) - 256, $signed($urandom_range(512)) - 256,
					$urandom_range(4000), $urandom);
		end
	endtask

	task automatic drain();
		wait (frames_pending.size() == 0 && !in_valid && poses_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		speed_r = 50; gain_r = 2048; upx_r = 0; upy_r = 16384; upz_r = 0;
		yaw_r = 0; pitch_r = 0; posx_r = 0; posy_r = 0; posz_r = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: extremes, yaw wrap both ways, pitch limits, every key set
		add_frame(0, 0, 0, 4'b0000);
		add_frame(32767, 0, 65535, 4'b1000);
		add_frame(-32768, 0, 65535, 4'b0100);
		add_frame(720, 0, 1000, 4'b0010);
		add_frame(-720, 0, 1000, 4'b0001);
		add_frame(0, 32767, 2000, 4'b1111);
		add_frame(0, -32768, 2000, 4'b1100);
		add_frame(0, 32767, 65535, 4'b0011);
		add_frame(1440, -32768, 65535, 4'b1010);
		add_frame(-1, 1, 1, 4'b0101);
		add_frame(32767, 32767, 65535, 4'b1001);
		add_frame(-32768, -32768, 32768, 4'b0110);
		drain();

		// saturating speed and gain, odd up vector, ignored index
		write_reg(CFG_MOVE_SPEED, 16'hffff);
		write_reg(CFG_LOOK_GAIN, 16'hffff);
		write_reg(CFG_UP_X, 16'h8000);
		write_reg(CFG_UP_Y, 16'h7fff);
		write_reg(CFG_UP_Z, 16'h8000);
		write_reg(3'd5, 16'h1234);
		write_reg(3'd7, 16'hffff);
		repeat (6) add_frame(0, 0, 65535, 4'b1000);
		repeat (6) add_frame(0, 0, 65535, 4'b0100);
		repeat (4) add_frame(100, 0, 65535, 4'b0011);
		recv_hold = 600;
		add_random(250);
		drain();

		// zero up vector forces a degenerate right, zero gain freezes angles
		write_reg(CFG_UP_X, 0);
		write_reg(CFG_UP_Y, 0);
		write_reg(CFG_UP_Z, 0);
		write_reg(CFG_MOVE_SPEED, 0);
		write_reg(CFG_LOOK_GAIN, 0);
		add_random(150);
		drain();

		// up vector along the x axis, with gain and speed back at their reset values
		write_reg(CFG_LOOK_GAIN, 2048);
		write_reg(CFG_MOVE_SPEED, 50);
		write_reg(CFG_UP_X, 16384);
		add_frame(0, 0, 1000, 4'b0011);
		calm = 1;
		add_random(300);
		wait (frames_pending.size() == 0);
		calm = 0;
		drain();

		repeat (5) begin
			write_reg(CFG_MOVE_SPEED, $urandom);
			write_reg(CFG_LOOK_GAIN, $urandom_range(1) ? $urandom : $urandom_range(8192));
			write_reg(CFG_UP_X, $urandom);
			write_reg(CFG_UP_Y, $urandom);
			write_reg(CFG_UP_Z, $urandom);
			add_random(200);
			drain();
		end

		if (mismatches == 0 && poses_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
